[rtl/core/alpha_blend_framebuffer_defines.svh]
// Assertion macros shared by the framebuffer RTL.
`ifndef ALPHA_BLEND_FRAMEBUFFER_DEFINES_SVH
`define ALPHA_BLEND_FRAMEBUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ABF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ABF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ABF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ABF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/abf_pkg.sv]
package abf_pkg;

    localparam int CHAN_W  = 8;
    localparam int COORD_W = 8;
    localparam int DIM_W   = 9;
    localparam int PIX_W   = 3 * CHAN_W;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // APB register map: register i at byte address 4*i
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_BLEND = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

endpackage

[rtl/core/abf_in_if.sv]
interface abf_in_if import abf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  src_red;
    logic [CHAN_W-1:0]  src_green;
    logic [CHAN_W-1:0]  src_blue;
    logic [CHAN_W-1:0]  src_alpha;

    modport source (
        output valid, func, x, y, src_red, src_green, src_blue, src_alpha,
        input  ready
    );
    modport sink (
        input  valid, func, x, y, src_red, src_green, src_blue, src_alpha,
        output ready
    );
endinterface

[rtl/core/abf_out_if.sv]
interface abf_out_if import abf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              range_error;

    modport source (
        output valid, red, green, blue, range_error,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, range_error,
        output ready
    );
endinterface

[rtl/core/alpha_blend_framebuffer.sv]
// RGB888 framebuffer with "over" alpha blending into a single-port pixel RAM.
// After reset the RAM is swept to black, one pixel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels (65536 at the defaults); no item is taken during
// the sweep, configuration writes are. The accept of an item issues the RAM
// read; the blend state then, once the output register is free, blends,
// writes back and loads the output register. With a single RAM port, used for
// a read and then a write per pixel, no item is taken until the last leaves
// the blend state. An item is taken while a result still waits in the output
// register; an out-of-range item skips the RAM, returns zeros, sets range_error.
`include "alpha_blend_framebuffer_defines.svh"

module alpha_blend_framebuffer import abf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    abf_in_if.sink            i_pix,
    abf_out_if.source         o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = COORD_W + DIM_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_BLEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [DIM_W-1:0]  r_frame_width, r_frame_height;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    // item held between accept and blend
    logic              r_func;
    logic              r_err;
    logic [ADDR_W-1:0] r_addr;
    t_pix              r_src;
    logic [CHAN_W-1:0] r_alpha;

    logic              r_out_valid, n_out_valid;
    t_pix              r_out_pix;
    logic              r_out_err;

    logic [DIM_W-1:0]  act_w, act_h;
    logic              in_range;
    logic [PROD_W-1:0] lin_addr;
    logic [ADDR_W-1:0] item_addr;
    logic              in_acc, out_free, blend_go, cfg_wr;

    logic              ram_en, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;
    t_pix              dst_pix, blend_pix;

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
        end else if (cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // saturate to the store's geometry
    always_comb begin
        act_w = r_frame_width;
        act_h = r_frame_height;
        if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            act_w = DIM_W'(MAX_WIDTH);
        end
        if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            act_h = DIM_W'(MAX_HEIGHT);
        end
    end

    // ---------------- input side ----------------
    assign i_pix.ready = (r_state == S_IDLE);
    assign in_acc      = i_pix.valid && i_pix.ready;

    assign in_range  = ({1'b0, i_pix.x} < act_w) && ({1'b0, i_pix.y} < act_h);
    assign lin_addr  = PROD_W'({1'b0, i_pix.y}) * PROD_W'(act_w) + PROD_W'(i_pix.x);
    assign item_addr = ADDR_W'(lin_addr);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func         <= i_pix.func;
            r_err          <= !in_range;
            r_addr         <= item_addr;
            r_src.red      <= i_pix.src_red;
            r_src.green    <= i_pix.src_green;
            r_src.blue     <= i_pix.src_blue;
            r_alpha        <= i_pix.src_alpha;
        end
    end

    // ---------------- blend and write back ----------------
    assign out_free = !r_out_valid || o_pix.ready;
    assign blend_go = (r_state == S_BLEND) && out_free;
    assign dst_pix  = t_pix'(ram_rdata);

    abf_blend u_blend (
        .i_src   (r_src),
        .i_dst   (dst_pix),
        .i_alpha (r_alpha),
        .o_pix   (blend_pix)
    );

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = blend_pix;
        case (r_state)
            S_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_en   = in_acc && in_range;
                ram_addr = item_addr;
            end
            S_BLEND: begin
                ram_en = blend_go && !r_err && (r_func == FUNC_BLEND);
                ram_we = 1'b1;
            end
            default: ;
        endcase
    end

    abf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------- control ----------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (blend_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (blend_go) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (blend_go) begin
            r_out_err <= r_err;
            if (r_err) begin
                r_out_pix <= '0;
            end else if (r_func == FUNC_BLEND) begin
                r_out_pix <= blend_pix;
            end else begin
                r_out_pix <= dst_pix;
            end
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.red         = r_out_pix.red;
    assign o_pix.green       = r_out_pix.green;
    assign o_pix.blue        = r_out_pix.blue;
    assign o_pix.range_error = r_out_err;

    // ---------------- assertions ----------------
    `ABF_ASSERT_NEXT(a_acc_to_blend, i_clk, i_rst_n, in_acc, r_state == S_BLEND,
        "accepted item did not move to blend")
    `ABF_ASSERT_NEXT(a_clear_done, i_clk, i_rst_n,
        (r_state == S_CLEAR) && (r_clr_addr == LAST_ADDR), r_state == S_IDLE,
        "clear sweep did not finish at last address")
    `ABF_ASSERT_NOW(a_wb_legal, i_clk, i_rst_n, (r_state == S_BLEND) && ram_en,
        !r_err && (r_func == FUNC_BLEND), "write-back for a read or out-of-range item")
    `ABF_ASSERT_NOW(a_err_black, i_clk, i_rst_n, o_pix.valid && o_pix.range_error,
        (o_pix.red == '0) && (o_pix.green == '0) && (o_pix.blue == '0),
        "range error with nonzero color")

endmodule

[rtl/core/abf_ram.sv]
module abf_ram #(
    parameter  int WIDTH = 24,
    parameter  int DEPTH = 65536,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/abf_blend.sv]
module abf_blend import abf_pkg::*; (
    input  t_pix              i_src,
    input  t_pix              i_dst,
    input  logic [CHAN_W-1:0] i_alpha,
    output t_pix              o_pix
);

    // floor((src*a + dst*(255-a)) / 255); the sum stays below 2^16, where
    // (v + (v >> 8) + 1) >> 8 is exact
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] src,
        input logic [CHAN_W-1:0] dst,
        input logic [CHAN_W-1:0] a
    );
        logic [2*CHAN_W-1:0] v;
        logic [2*CHAN_W:0]   t;
        v = ({8'd0, src} * {8'd0, a}) + ({8'd0, dst} * {8'd0, 8'd255 - a});
        t = {1'b0, v} + {9'd0, v[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

    always_comb begin
        o_pix.red   = blend_chan(i_src.red,   i_dst.red,   i_alpha);
        o_pix.green = blend_chan(i_src.green, i_dst.green, i_alpha);
        o_pix.blue  = blend_chan(i_src.blue,  i_dst.blue,  i_alpha);
    end

endmodule
